// ===== src/frame_change_bounding_box_assert.svh =====
// Assertion macros for the changed-rectangle finder.
// Included by the top level; no other dependencies.
`ifndef FRAME_CHANGE_BOUNDING_BOX_ASSERT_SVH
`define FRAME_CHANGE_BOUNDING_BOX_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check a property on clk_i, disabled while in reset
`define FCBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check a property on clk_i, also while in reset
`define FCBB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FCBB_ASSERT(lbl, prop, msg)
`define FCBB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/fcbb_pkg.sv =====
// Shared types and constants of the changed-rectangle finder.
// No dependencies.
package fcbb_pkg;

  localparam int unsigned DimW   = 13;  // frame dimension registers
  localparam int unsigned PixW   = 32;  // ARGB pixel
  localparam int unsigned PosW   = 12;  // rectangle left/top fields
  localparam int unsigned SizeW  = 13;  // rectangle width/height fields
  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0] AlphaOpaque = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_BLEND_ALLOWED = 2'd2
  } cfg_idx_e;

  // status from the tracker for the pixel in the input register
  typedef struct packed {
    logic last;         // pixel closes the frame
    logic any_change;   // merged: some pair differed so far
    logic translucent;  // merged: some differing new pixel not opaque
  } trk_status_t;

endpackage

// ===== src/fcbb_if.sv =====
// Valid/ready channel interfaces for pixel pairs and rectangle results.
// Depends on fcbb_pkg.
interface fcbb_pix_if import fcbb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] new_pixel;
  logic [PixW-1:0] old_pixel;

  modport source (output valid, new_pixel, old_pixel, input ready);
  modport sink (input valid, new_pixel, old_pixel, output ready);
endinterface

interface fcbb_rect_if import fcbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PosW-1:0]  rect_left;
  logic [PosW-1:0]  rect_top;
  logic [SizeW-1:0] rect_width;
  logic [SizeW-1:0] rect_height;
  logic             use_blend;
  logic             frames_identical;

  modport source (output valid, rect_left, rect_top, rect_width, rect_height,
                  use_blend, frames_identical, input ready);
  modport sink (input valid, rect_left, rect_top, rect_width, rect_height,
                use_blend, frames_identical, output ready);
endinterface

// ===== src/fcbb_tracker.sv =====
// Raster position counters and changed-area min/max trackers.
// Depends on fcbb_pkg.
module fcbb_tracker import fcbb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,     // abandon the frame in progress
  input  logic            advance_i,   // pixel in the input register is consumed
  input  logic [DimW-1:0] width_i,     // clamped frame width
  input  logic [DimW-1:0] height_i,    // clamped frame height
  input  logic [PixW-1:0] new_pixel_i,
  input  logic [PixW-1:0] old_pixel_i,
  output trk_status_t     status_o,
  output logic [CW-1:0]   min_col_o,
  output logic [CW-1:0]   max_col_o,
  output logic [RW-1:0]   min_row_o,
  output logic [RW-1:0]   max_row_o
);

  logic [CW-1:0] col_q, col_d, min_col_q, min_col_d, max_col_q, max_col_d;
  logic [RW-1:0] row_q, row_d, min_row_q, min_row_d, max_row_q, max_row_d;
  logic          any_q, any_d, trans_q, trans_d;
  logic          diff, row_end, last;
  logic [CW-1:0] mn_c, mx_c;
  logic [RW-1:0] mn_r, mx_r;
  logic          any_m, trans_m;

  // end of row / end of frame for the current position
  assign diff    = (new_pixel_i != old_pixel_i);
  assign row_end = (32'(col_q) + 32'd1) >= 32'(width_i);
  assign last    = row_end && ((32'(row_q) + 32'd1) >= 32'(height_i));

  // merge the current pixel into the trackers
  always_comb begin
    mn_c    = min_col_q;
    mx_c    = max_col_q;
    mn_r    = min_row_q;
    mx_r    = max_row_q;
    any_m   = any_q;
    trans_m = trans_q;
    if (diff) begin
      if (!any_q) begin
        mn_c = col_q;
        mx_c = col_q;
        mn_r = row_q;
      end else begin
        if (col_q < min_col_q) mn_c = col_q;
        if (col_q > max_col_q) mx_c = col_q;
      end
      mx_r  = row_q;
      any_m = 1'b1;
      if (new_pixel_i[PixW-1 -: 8] != AlphaOpaque) trans_m = 1'b1;
    end
  end

  assign status_o  = '{last: last, any_change: any_m, translucent: trans_m};
  assign min_col_o = mn_c;
  assign max_col_o = mx_c;
  assign min_row_o = mn_r;
  assign max_row_o = mx_r;

  // next state: clear on frame end or abandon, else store merge and step
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    min_col_d = min_col_q;
    max_col_d = max_col_q;
    min_row_d = min_row_q;
    max_row_d = max_row_q;
    any_d     = any_q;
    trans_d   = trans_q;
    if (clear_i || (advance_i && last)) begin
      col_d     = '0;
      row_d     = '0;
      min_col_d = '1;
      max_col_d = '0;
      min_row_d = '1;
      max_row_d = '0;
      any_d     = 1'b0;
      trans_d   = 1'b0;
    end else if (advance_i) begin
      min_col_d = mn_c;
      max_col_d = mx_c;
      min_row_d = mn_r;
      max_row_d = mx_r;
      any_d     = any_m;
      trans_d   = trans_m;
      if (row_end) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      min_col_q <= '1;
      max_col_q <= '0;
      min_row_q <= '1;
      max_row_q <= '0;
      any_q     <= 1'b0;
      trans_q   <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      min_col_q <= min_col_d;
      max_col_q <= max_col_d;
      min_row_q <= min_row_d;
      max_row_q <= max_row_d;
      any_q     <= any_d;
      trans_q   <= trans_d;
    end
  end

endmodule

// ===== src/fcbb_result.sv =====
// Rectangle formatting and the result output register.
// Depends on fcbb_pkg and fcbb_rect_if.
module fcbb_result import fcbb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,   // frame closes: capture a result
  input  trk_status_t     status_i,
  input  logic [CW-1:0]   min_col_i,
  input  logic [CW-1:0]   max_col_i,
  input  logic [RW-1:0]   min_row_i,
  input  logic [RW-1:0]   max_row_i,
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  input  logic            blend_allowed_i,
  fcbb_rect_if.source     rect_o
);

  logic             valid_q, valid_d;
  logic [PosW-1:0]  left_q, left_d, top_q, top_d;
  logic [SizeW-1:0] rw_q, rw_d, rh_q, rh_d;
  logic             blend_q, blend_d, ident_q, ident_d;
  logic [31:0]      left_w, top_w, rw_w, rh_w;

  // changed rectangle, or the degenerate one when nothing differed
  always_comb begin
    left_w = 32'(min_col_i) & ~32'd1;
    top_w  = 32'(min_row_i) & ~32'd1;
    rw_w   = 32'(max_col_i) + 32'd1 - left_w;
    rh_w   = 32'(max_row_i) + 32'd1 - top_w;
    if (!status_i.any_change) begin
      rw_w = 32'd1;
      rh_w = 32'd1;
      if (width_i[0] && height_i[0]) begin
        left_w = 32'(width_i) - 32'd1;
        top_w  = 32'(height_i) - 32'd1;
      end else begin
        left_w = '0;
        top_w  = '0;
      end
    end
  end

  // hold the result until taken
  always_comb begin
    valid_d = valid_q && !rect_o.ready;
    left_d  = left_q;
    top_d   = top_q;
    rw_d    = rw_q;
    rh_d    = rh_q;
    blend_d = blend_q;
    ident_d = ident_q;
    if (load_i) begin
      valid_d = 1'b1;
      left_d  = left_w[PosW-1:0];
      top_d   = top_w[PosW-1:0];
      rw_d    = rw_w[SizeW-1:0];
      rh_d    = rh_w[SizeW-1:0];
      blend_d = blend_allowed_i && !status_i.translucent;
      ident_d = !status_i.any_change;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    top_q   <= top_d;
    rw_q    <= rw_d;
    rh_q    <= rh_d;
    blend_q <= blend_d;
    ident_q <= ident_d;
  end

  assign rect_o.valid            = valid_q;
  assign rect_o.rect_left        = left_q;
  assign rect_o.rect_top         = top_q;
  assign rect_o.rect_width       = rw_q;
  assign rect_o.rect_height      = rh_q;
  assign rect_o.use_blend        = blend_q;
  assign rect_o.frames_identical = ident_q;

endmodule

// ===== src/frame_change_bounding_box.sv =====
// Top level of the changed-rectangle finder: config registers, input register,
// tracker and result stage. Depends on fcbb_pkg, fcbb_if, fcbb_tracker, fcbb_result.
//
//   channel  dir  handshake      payload
//   pix_i    in   valid/ready    new_pixel, old_pixel (ARGB)
//   rect_o   out  valid/ready    rect_left/top/width/height, use_blend,
//                                frames_identical (one per frame)
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// One pixel pair per cycle. A pair sits in the input register, where the
// tracker compares and merges it; the last pair of a frame loads the result
// register as it leaves, so a result passes the input register and then the
// result register. Reset clears all control state at once, no sweep.
// Only the last pair of a frame stalls, and only while a previous result is
// still waiting on rect_o; while it stalls, no new pair is accepted.
module frame_change_bounding_box import fcbb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DimW-1:0]    cfg_data_i,
  fcbb_pix_if.sink           pix_i,
  fcbb_rect_if.source        rect_o
);

  `include "frame_change_bounding_box_assert.svh"

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [DimW-1:0] width_q, height_q;
  logic            blend_q;
  logic [DimW-1:0] width_c, height_c;
  logic            dim_clear;

  logic            s1_valid_q, s1_valid_d;
  logic [PixW-1:0] s1_new_q, s1_old_q;
  logic            s1_hold, s1_adv, in_fire;

  trk_status_t     trk_st;
  logic [CW-1:0]   min_col, max_col;
  logic [RW-1:0]   min_row, max_row;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(1);
      height_q <= DimW'(1);
      blend_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:   width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT:  height_q <= cfg_data_i;
        CFG_BLEND_ALLOWED: blend_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign dim_clear = cfg_we_i &&
                     ((cfg_idx_i == CFG_FRAME_WIDTH) || (cfg_idx_i == CFG_FRAME_HEIGHT));

  // clamp dimensions: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    width_c = width_q;
    if (width_q == '0) width_c = DimW'(1);
    else if (32'(width_q) > MAX_WIDTH) width_c = DimW'(MAX_WIDTH);
    height_c = height_q;
    if (height_q == '0) height_c = DimW'(1);
    else if (32'(height_q) > MAX_HEIGHT) height_c = DimW'(MAX_HEIGHT);
  end

  // input register: stall only a frame-closing pair behind a waiting result
  assign s1_hold     = s1_valid_q && trk_st.last && rect_o.valid && !rect_o.ready;
  assign s1_adv      = s1_valid_q && !s1_hold;
  assign pix_i.ready = !s1_hold;
  assign in_fire     = pix_i.valid && pix_i.ready;
  assign s1_valid_d  = in_fire || s1_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_new_q <= pix_i.new_pixel;
      s1_old_q <= pix_i.old_pixel;
    end
  end

  fcbb_tracker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (dim_clear),
    .advance_i   (s1_adv),
    .width_i     (width_c),
    .height_i    (height_c),
    .new_pixel_i (s1_new_q),
    .old_pixel_i (s1_old_q),
    .status_o    (trk_st),
    .min_col_o   (min_col),
    .max_col_o   (max_col),
    .min_row_o   (min_row),
    .max_row_o   (max_row)
  );

  fcbb_result #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_result (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (s1_adv && trk_st.last),
    .status_i        (trk_st),
    .min_col_i       (min_col),
    .max_col_i       (max_col),
    .min_row_i       (min_row),
    .max_row_i       (max_row),
    .width_i         (width_c),
    .height_i        (height_c),
    .blend_allowed_i (blend_q),
    .rect_o          (rect_o)
  );

  // a closing pair always yields a result in the next cycle
  `FCBB_ASSERT(a_close_gives_result, s1_adv && trk_st.last |=> rect_o.valid, "frame end lost")
  // a held pair is never dropped from the input register
  `FCBB_ASSERT(a_hold_keeps_pair, s1_hold |=> s1_valid_q, "stalled pair dropped")
  // left and top of every result are even
  `FCBB_ASSERT(a_even_origin, rect_o.valid |-> !rect_o.rect_left[0] && !rect_o.rect_top[0], "odd origin")
  // no result is shown while reset is applied
  `FCBB_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !rect_o.valid, "result during reset")

endmodule
